// ----- rtl/ulaw_rtp_packetizer_core_defines.svh -----
// Assertion macros shared by the queue and back-end RTL files.
`ifndef ULAW_RTP_PACKETIZER_CORE_DEFINES_SVH
`define ULAW_RTP_PACKETIZER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ULAW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ULAW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ULAW_ASSERT(lbl, clk, rst_n, prop, msg)
`define ULAW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/ulawrtp_pkg.sv -----
package ulawrtp_pkg;

    localparam int SAMPLES_PER_PACKET = 160;
    localparam int SIDX_W             = 8;

    localparam int HDR_BYTES = 12;
    localparam int SR_BYTES  = 28;
    localparam int BIDX_W    = 5;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [16:0] ULAW_CLIP        = 17'd32635;
    localparam logic [15:0] ULAW_BIAS        = 16'h0084;
    localparam logic [7:0]  RTP_VERSION      = 8'h80;
    localparam logic [7:0]  RTP_PT_PCMU      = 8'h00;
    localparam logic [7:0]  RTCP_SR_TYPE     = 8'd200;
    localparam logic [7:0]  RTCP_SR_LEN_HI   = 8'h00;
    localparam logic [7:0]  RTCP_SR_LEN_LO   = 8'd6;
    localparam logic [31:0] NTP_EPOCH_OFFSET = 32'd2208988800;
    localparam logic [29:0] NS_MAX           = 30'd999999999;
    localparam logic [30:0] NS_PER_SECOND    = 31'd1000000000;

    // ceil(2^74 / 5^9): ns * this >> 51 equals floor(ns * 2^32 / 10^9) for every ns below 10^9
    localparam logic [53:0] NTP_FRAC_MUL    = 54'd9671406556917034;
    localparam logic [26:0] NTP_FRAC_MUL_LO = NTP_FRAC_MUL[26:0];
    localparam logic [26:0] NTP_FRAC_MUL_HI = NTP_FRAC_MUL[53:27];

    localparam logic [31:0] SOURCE_ID_RESET       = 32'd12345;
    localparam logic [15:0] INITIAL_SEQ_RESET     = 16'd0;
    localparam logic [15:0] REPORT_INTERVAL_RESET = 16'd50;

    localparam logic [1:0] CFG_SOURCE_ID       = 2'd0;
    localparam logic [1:0] CFG_INITIAL_SEQ     = 2'd1;
    localparam logic [1:0] CFG_REPORT_INTERVAL = 2'd2;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic [31:0]        wall_seconds;
        logic [29:0]        wall_nanoseconds;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       channel;
        logic       packet_end;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  code;
        logic        hdr;
        logic [15:0] seq;
        logic [31:0] hdr_time;
        logic        last;
        logic        report;
        logic [31:0] ntp_sec;
        logic [29:0] ns;
        logic [31:0] sr_time;
        logic [31:0] sr_packets;
        logic [31:0] sr_octets;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic        busy;
        logic [31:0] frac;
    } t_div_stat;

    function automatic logic [7:0] ulaw_encode(input logic [15:0] raw);
        logic        neg;
        logic [16:0] mag;
        logic [15:0] biased;
        logic [2:0]  seg;
        logic [3:0]  mant;
        neg = raw[15];
        mag = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        if (mag > ULAW_CLIP) begin
            mag = ULAW_CLIP;
        end
        biased = mag[15:0] + ULAW_BIAS;
        seg = 3'd0;
        for (int s = 1; s < 8; s++) begin
            if (biased[s + 7]) begin
                seg = 3'(s);
            end
        end
        mant = 4'(biased >> ({1'b0, seg} + 4'd3));
        return ~{neg, seg, mant};
    endfunction

endpackage

// ----- rtl/ulaw_rtp_packetizer_core.sv -----
// Each accepted word's first byte passes the queue, the command register and the output register.
// Output: one byte per cycle while i_out_ready is high and no report waits for the NTP fraction;
// a word gives one byte, 13 with its RTP header, and one that closes a report period adds 28 bytes.
// Input is taken while the 2-entry command queue between front and back has room.
// Reset (i_rst_n low, synchronous) clears counters, queue and output; registers take defaults.
module ulaw_rtp_packetizer_core import ulawrtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic        push;
    logic        pop;
    t_cmd        push_cmd;
    t_cmd        head_cmd;
    t_q_stat     q_stat;
    logic [31:0] source_id;
    logic        div_start;
    t_div_stat   div_stat;

    ulawrtp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .o_source_id (source_id)
    );

    ulawrtp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    ulawrtp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_ns    (head_cmd.ns),
        .o_stat  (div_stat)
    );

    ulawrtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_cmd     (head_cmd),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .i_source_id (source_id),
        .i_div       (div_stat),
        .o_div_start (div_start),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/ulawrtp_front.sv -----
module ulawrtp_front import ulawrtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_cmd        o_cmd,
    output logic [31:0] o_source_id
);

    logic [31:0]       r_source_id;
    logic [15:0]       r_initial_seq;
    logic [15:0]       r_report_interval;

    logic [SIDX_W-1:0] r_sample_idx, n_sample_idx;
    logic [31:0]       r_packets, n_packets;
    logic [31:0]       r_rtp_time, n_rtp_time;
    logic [31:0]       r_octets, n_octets;
    logic [15:0]       r_countdown, n_countdown;

    logic [SIDX_W-1:0] idx_inc;
    logic [15:0]       cd_inc;
    logic              last;
    logic              report;
    logic              accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_stat.full;
    assign accept      = i_in_valid && o_in_ready;
    assign o_push      = accept;
    assign o_source_id = r_source_id;

    assign idx_inc = r_sample_idx + 1'b1;
    assign last    = idx_inc >= SIDX_W'(SAMPLES_PER_PACKET);
    assign cd_inc  = r_countdown + 1'b1;
    assign report  = last && ((cd_inc >= r_report_interval) || (r_report_interval == 16'd0));

    always_comb begin
        n_sample_idx = last ? '0 : idx_inc;
        n_packets    = r_packets;
        n_rtp_time   = r_rtp_time;
        n_octets     = r_octets;
        n_countdown  = r_countdown;
        if (last) begin
            n_packets   = r_packets + 32'd1;
            n_rtp_time  = r_rtp_time + 32'(SAMPLES_PER_PACKET);
            n_octets    = r_octets + 32'(SAMPLES_PER_PACKET);
            n_countdown = report ? 16'd0 : cd_inc;
        end
    end

    always_comb begin
        o_cmd.code       = ulaw_encode(i_in_data.pcm_sample);
        o_cmd.hdr        = (r_sample_idx == '0);
        o_cmd.seq        = r_initial_seq + r_packets[15:0];
        o_cmd.hdr_time   = r_rtp_time;
        o_cmd.last       = last;
        o_cmd.report     = report;
        o_cmd.ntp_sec    = i_in_data.wall_seconds + NTP_EPOCH_OFFSET;
        // saturate out-of-range nanoseconds
        o_cmd.ns         = (i_in_data.wall_nanoseconds > NS_MAX) ? NS_MAX
                                                                 : i_in_data.wall_nanoseconds;
        o_cmd.sr_time    = n_rtp_time;
        o_cmd.sr_packets = n_packets;
        o_cmd.sr_octets  = n_octets;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_id       <= SOURCE_ID_RESET;
            r_initial_seq     <= INITIAL_SEQ_RESET;
            r_report_interval <= REPORT_INTERVAL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_ID:       r_source_id       <= i_cfg_data;
                CFG_INITIAL_SEQ:     r_initial_seq     <= i_cfg_data[15:0];
                CFG_REPORT_INTERVAL: r_report_interval <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_idx <= '0;
            r_packets    <= '0;
            r_rtp_time   <= '0;
            r_octets     <= '0;
            r_countdown  <= '0;
        end else if (accept) begin
            r_sample_idx <= n_sample_idx;
            r_packets    <= n_packets;
            r_rtp_time   <= n_rtp_time;
            r_octets     <= n_octets;
            r_countdown  <= n_countdown;
        end
    end

endmodule

// ----- rtl/ulawrtp_fifo.sv -----
`include "ulaw_rtp_packetizer_core_defines.svh"

module ulawrtp_fifo import ulawrtp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    `ULAW_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> !o_stat.full, "push into full queue")
    `ULAW_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> !o_stat.empty, "pop from empty queue")
    `ULAW_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QDEPTH), "queue count too big")

endmodule

// ----- rtl/ulawrtp_div.sv -----
module ulawrtp_div import ulawrtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_ns,
    output t_div_stat   o_stat
);

    // ns * 2^32 / 10^9 by reciprocal multiply, one half of the constant per cycle:
    // first keep (ns * low half) >> 27, then add ns * high half and keep bits 55:24
    logic [29:0] r_ns;
    logic [29:0] r_lo;
    logic [31:0] r_frac;
    logic        r_step;
    logic        r_busy;
    logic [26:0] mul_k;
    logic [56:0] prod;
    logic [57:0] acc;

    assign mul_k = r_step ? NTP_FRAC_MUL_HI : NTP_FRAC_MUL_LO;
    assign prod  = 57'(r_ns) * 57'(mul_k);
    assign acc   = 58'(prod) + 58'(r_lo);

    assign o_stat.busy = r_busy;
    assign o_stat.frac = r_frac;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ns <= i_ns;
        end else if (r_busy) begin
            if (!r_step) begin
                r_lo <= prod[56:27];
            end else begin
                r_frac <= acc[55:24];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 1'b0;
        end else if (r_busy) begin
            r_step <= 1'b1;
            if (r_step) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/ulawrtp_back.sv -----
`include "ulaw_rtp_packetizer_core_defines.svh"

module ulawrtp_back import ulawrtp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_q_cmd,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    input  logic [31:0] i_source_id,
    input  t_div_stat   i_div,
    output logic        o_div_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data
);

    localparam logic [1:0] PH_HDR  = 2'd0;
    localparam logic [1:0] PH_CODE = 2'd1;
    localparam logic [1:0] PH_SR   = 2'd2;

    logic [1:0]        r_phase, n_phase;
    logic [BIDX_W-1:0] r_idx, n_idx;
    logic              r_busy, n_busy;
    t_cmd              r_cmd;
    logic              r_ovalid;
    t_out_word         r_odata;

    logic [HDR_BYTES*8-1:0] hdr_word;
    logic [SR_BYTES*8-1:0]  sr_word;
    t_out_word              cur;
    logic                   out_free;
    logic                   stall;
    logic                   emit;
    logic                   item_done;
    logic                   load;

    assign hdr_word = {RTP_VERSION, RTP_PT_PCMU, r_cmd.seq, r_cmd.hdr_time, i_source_id};
    assign sr_word  = {RTP_VERSION, RTCP_SR_TYPE, RTCP_SR_LEN_HI, RTCP_SR_LEN_LO,
                       i_source_id, r_cmd.ntp_sec, i_div.frac, r_cmd.sr_time,
                       r_cmd.sr_packets, r_cmd.sr_octets};

    assign out_free  = !r_ovalid || i_out_ready;
    // hold the report until the NTP fraction is ready
    assign stall     = (r_phase == PH_SR) && i_div.busy;
    assign emit      = r_busy && out_free && !stall;
    assign item_done = emit && (((r_phase == PH_CODE) && !r_cmd.report) ||
                                ((r_phase == PH_SR) && (r_idx == BIDX_W'(SR_BYTES - 1))));
    assign load        = !i_q_stat.empty && (!r_busy || item_done);
    assign o_pop       = load;
    assign o_div_start = load && i_q_cmd.report;

    always_comb begin
        cur = '0;
        unique case (r_phase)
            PH_HDR: begin
                cur.out_byte = hdr_word[(HDR_BYTES - 1 - int'(r_idx)) * 8 +: 8];
            end
            PH_CODE: begin
                cur.out_byte   = r_cmd.code;
                cur.packet_end = r_cmd.last;
            end
            PH_SR: begin
                cur.out_byte   = sr_word[(SR_BYTES - 1 - int'(r_idx)) * 8 +: 8];
                cur.channel    = 1'b1;
                cur.packet_end = (r_idx == BIDX_W'(SR_BYTES - 1));
            end
            default: ;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_busy  = r_busy;
        if (emit) begin
            unique case (r_phase)
                PH_HDR: begin
                    if (r_idx == BIDX_W'(HDR_BYTES - 1)) begin
                        n_phase = PH_CODE;
                        n_idx   = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                PH_CODE: begin
                    n_phase = PH_SR;
                    n_idx   = '0;
                end
                PH_SR: begin
                    n_idx = r_idx + 1'b1;
                end
                default: ;
            endcase
        end
        if (item_done) begin
            n_busy = 1'b0;
        end
        if (load) begin
            n_busy  = 1'b1;
            n_phase = i_q_cmd.hdr ? PH_HDR : PH_CODE;
            n_idx   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_cmd;
        end
        if (emit) begin
            r_odata <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CODE;
            r_idx    <= '0;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_busy  <= n_busy;
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    `ULAW_ASSERT(a_div_owner, i_clk, i_rst_n, i_div.busy |-> (r_busy && r_cmd.report), "divider busy without a report")
    `ULAW_ASSERT(a_sr_has_report, i_clk, i_rst_n, (r_busy && r_phase == PH_SR) |-> r_cmd.report, "report bytes without a report")
    `ULAW_ASSERT(a_hdr_idx, i_clk, i_rst_n, (r_busy && r_phase == PH_HDR) |-> (r_idx < BIDX_W'(HDR_BYTES)), "header index out of range")

endmodule

// ----- bench/ulaw_rtp_packetizer_core_test.sv -----
`timescale 1ns / 1ps

module ulaw_rtp_packetizer_core_test;
    import ulawrtp_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int N_ROWS       = 20;
    localparam int PHASE_WORDS  = 53;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [15:0] pcm;
        logic [31:0] sec;
        logic [29:0] ns;
        logic        pinned;
        logic [7:0]  code;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    // code override that travels with the input word
    logic        pin_valid = 1'b0;
    logic [7:0]  pin_code = '0;

    // receiver control
    int stall_pct = 0;
    int hold_asked = 0;
    int hold_taken = 0;
    int hold_left = 0;

    // sender control
    int send_idle_pct = 0;
    int words_sent = 0;
    int closings = 0;

    // predictor copy of the block
    logic [31:0] ssrc = SOURCE_ID_RESET;
    logic [15:0] seq_base = INITIAL_SEQ_RESET;
    logic [15:0] report_every = REPORT_INTERVAL_RESET;
    logic [7:0]  sample_idx = '0;
    logic [31:0] pkt_count = '0;
    logic [31:0] rtp_stamp = '0;
    logic [31:0] payload_total = '0;
    logic [15:0] since_report = '0;

    t_out_word expected_bytes[$];
    int errors = 0;

    t_row rows [N_ROWS] = '{
        '{16'h0000, 32'h0000_0000, 30'd0,          1'b1, 8'hFF},
        '{16'h0001, 32'hFFFF_FFFF, 30'h3FFF_FFFF,  1'b1, 8'hFF},
        '{16'hFFFF, 32'h0000_0000, 30'd999999999,  1'b1, 8'h7F},
        '{16'h7FFF, 32'hFFFF_FFFF, 30'd0,          1'b1, 8'h80},
        '{16'h8000, 32'h0000_0000, 30'h3FFF_FFFF,  1'b1, 8'h00},
        '{16'h7F7B, 32'h1234_5678, 30'd1,          1'b0, 8'h00},
        '{16'h7F7C, 32'h8000_0000, 30'd500000000,  1'b0, 8'h00},
        '{16'h8085, 32'h7FFF_FFFF, 30'd1000000000, 1'b0, 8'h00},
        '{16'h8084, 32'hDEAD_BEEF, 30'd999999998,  1'b0, 8'h00},
        '{16'h007B, 32'h0000_0001, 30'h2AAA_AAAA,  1'b0, 8'h00},
        '{16'h007C, 32'hAAAA_AAAA, 30'h1555_5555,  1'b0, 8'h00},
        '{16'hFF84, 32'h5555_5555, 30'd123456789,  1'b0, 8'h00},
        '{16'h3F7C, 32'h0F0F_0F0F, 30'd0,          1'b0, 8'h00},
        '{16'h3F7B, 32'hF0F0_F0F0, 30'd999999999,  1'b0, 8'h00},
        '{16'hC084, 32'h0000_0000, 30'd42,         1'b0, 8'h00},
        '{16'h5555, 32'hFFFF_FFFF, 30'h3FFF_FFFF,  1'b0, 8'h00},
        '{16'hAAAA, 32'h0000_0000, 30'd0,          1'b0, 8'h00},
        '{16'h0F7C, 32'h1111_1111, 30'd777,        1'b0, 8'h00},
        '{16'h1F7C, 32'h2222_2222, 30'd888,        1'b0, 8'h00},
        '{16'hF084, 32'h3333_3333, 30'd999,        1'b0, 8'h00}
    };

    ulaw_rtp_packetizer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] mulaw_code(input logic [15:0] raw);
        logic [16:0] mag;
        int          seg;
        logic [3:0]  mant;
        mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        if (mag > ULAW_CLIP) begin
            mag = ULAW_CLIP;
        end
        mag = mag + {1'b0, ULAW_BIAS};
        seg = 7;
        while (seg > 0 && mag < (17'd1 << (seg + 7))) begin
            seg--;
        end
        mant = 4'(mag >> (seg + 3));
        return ~{raw[15], 3'(seg), mant};
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic ch, input logic last);
        t_out_word w;
        w.out_byte   = b;
        w.channel    = ch;
        w.packet_end = last;
        expected_bytes.push_back(w);
    endtask

    task automatic push_be32(input logic [31:0] v, input logic ch, input logic last);
        push_byte(v[31:24], ch, 1'b0);
        push_byte(v[23:16], ch, 1'b0);
        push_byte(v[15:8], ch, 1'b0);
        push_byte(v[7:0], ch, last);
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            CFG_SOURCE_ID:       ssrc = val;
            CFG_INITIAL_SEQ:     seq_base = val[15:0];
            CFG_REPORT_INTERVAL: report_every = val[15:0];
            default: ;
        endcase
    endtask

    // Work out every byte one accepted sample causes.
    task automatic packetize_sample(input t_in_word w, input logic pinned,
                                    input logic [7:0] pcode);
        logic [15:0]     seq;
        logic [7:0]      code;
        logic            last;
        longint unsigned ns64;
        logic [31:0]     ntp_sec;
        logic [31:0]     ntp_frac;
        code = pinned ? pcode : mulaw_code(w.pcm_sample);
        if (sample_idx == 8'd0) begin
            seq = seq_base + pkt_count[15:0];
            push_byte(RTP_VERSION, 1'b0, 1'b0);
            push_byte(RTP_PT_PCMU, 1'b0, 1'b0);
            push_byte(seq[15:8], 1'b0, 1'b0);
            push_byte(seq[7:0], 1'b0, 1'b0);
            push_be32(rtp_stamp, 1'b0, 1'b0);
            push_be32(ssrc, 1'b0, 1'b0);
        end
        sample_idx = sample_idx + 8'd1;
        last = (int'(sample_idx) >= SAMPLES_PER_PACKET);
        push_byte(code, 1'b0, last);
        if (last) begin
            sample_idx    = '0;
            pkt_count     = pkt_count + 32'd1;
            rtp_stamp     = rtp_stamp + 32'(SAMPLES_PER_PACKET);
            payload_total = payload_total + 32'(SAMPLES_PER_PACKET);
            since_report  = since_report + 16'd1;
            if (since_report >= report_every || report_every == 16'd0) begin
                ns64 = w.wall_nanoseconds;
                if (ns64 > NS_MAX) begin
                    ns64 = NS_MAX;
                end
                ntp_sec  = w.wall_seconds + NTP_EPOCH_OFFSET;
                ntp_frac = 32'((ns64 << 32) / 64'(NS_PER_SECOND));
                since_report = '0;
                push_byte(RTP_VERSION, 1'b1, 1'b0);
                push_byte(RTCP_SR_TYPE, 1'b1, 1'b0);
                push_byte(RTCP_SR_LEN_HI, 1'b1, 1'b0);
                push_byte(RTCP_SR_LEN_LO, 1'b1, 1'b0);
                push_be32(ssrc, 1'b1, 1'b0);
                push_be32(ntp_sec, 1'b1, 1'b0);
                push_be32(ntp_frac, 1'b1, 1'b0);
                push_be32(rtp_stamp, 1'b1, 1'b0);
                push_be32(pkt_count, 1'b1, 1'b0);
                push_be32(payload_total, 1'b1, 1'b1);
            end
        end
    endtask

    task automatic note_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    task automatic check_byte(input t_out_word got);
        t_out_word want;
        if (expected_bytes.size() == 0) begin
            note_mismatch($sformatf("unexpected word byte %02h ch %0b end %0b",
                                    got.out_byte, got.channel, got.packet_end));
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.channel !== want.channel ||
                got.packet_end !== want.packet_end) begin
                note_mismatch($sformatf("expected %02h ch %0b end %0b, got %02h ch %0b end %0b",
                                        want.out_byte, want.channel, want.packet_end,
                                        got.out_byte, got.channel, got.packet_end));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                apply_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && o_in_ready) begin
                packetize_sample(i_in_data, pin_valid, pin_code);
            end
            if (o_out_valid && i_out_ready) begin
                check_byte(o_out_data);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            i_out_ready <= 1'b0;
            hold_taken <= hold_taken + 1;
            hold_left <= LONG_HOLD;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(input t_in_word w, input logic pinned, input logic [7:0] pcode);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        pin_valid  <= pinned;
        pin_code   <= pcode;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    // Drop valid and hold until every expected byte has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [31:0] src, input logic [15:0] seq,
                             input logic [15:0] every);
        write_reg(CFG_SOURCE_ID, src);
        write_reg(CFG_INITIAL_SEQ, {16'($urandom_range(65535)), 16'h0} | 32'(seq));
        write_reg(CFG_REPORT_INTERVAL, {16'($urandom_range(65535)), 16'h0} | 32'(every));
        if ($urandom_range(1) == 1) begin
            write_reg(CFG_UNUSED, $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word random_word(input int closing_no, input bit closing);
        t_in_word w;
        case ($urandom_range(7))
            0: w.pcm_sample = 16'h7FFF;
            1: w.pcm_sample = 16'h8000;
            2: w.pcm_sample = 16'(int'($urandom_range(255)) - 128);
            default: w.pcm_sample = 16'($urandom);
        endcase
        w.wall_seconds = $urandom;
        w.wall_nanoseconds = 30'($urandom);
        // steer the report's clock input: saturate on the first report, in range after
        if (closing) begin
            if (closing_no == 0) begin
                w.wall_nanoseconds = 30'($urandom_range(30'h3FFF_FFFF, int'(NS_MAX) + 1));
            end else begin
                w.wall_nanoseconds = 30'($urandom_range(int'(NS_MAX), 0));
            end
        end
        return w;
    endfunction

    initial begin
        t_in_word w;
        bit       closing;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            w.pcm_sample       = rows[r].pcm;
            w.wall_seconds     = rows[r].sec;
            w.wall_nanoseconds = rows[r].ns;
            send_word(w, rows[r].pinned, rows[r].code);
        end

        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0: configure(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                1: configure($urandom, 16'($urandom), 16'd0);
                2: configure(32'h0, 16'h0, 16'd1);
                default: configure($urandom, 16'hFFFF, 16'd2);
            endcase
            case (p)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 75; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 75; end
                default: begin send_idle_pct = 26; stall_pct <= 26; end
            endcase
            if (p == 2) begin
                hold_asked <= hold_asked + 1;
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (p == 1 && k == PHASE_WORDS / 2) begin
                    drain();
                end
                closing = ((words_sent % SAMPLES_PER_PACKET) == SAMPLES_PER_PACKET - 1);
                w = random_word(closings, closing);
                if (closing) begin
                    closings++;
                end
                send_word(w, 1'b0, 8'h00);
            end
        end

        drain();
        repeat (64) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            note_mismatch($sformatf("%0d expected words never came", expected_bytes.size()));
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ulawrtp_pkg.sv
rtl/ulawrtp_front.sv
rtl/ulawrtp_fifo.sv
rtl/ulawrtp_div.sv
rtl/ulawrtp_back.sv
rtl/ulaw_rtp_packetizer_core.sv
bench/ulaw_rtp_packetizer_core_test.sv
